// ===== rtl/rmc_pkg.sv =====
// ----------------------------------------------------------------------------
// RSA modular exponentiation package
// Shared widths, register indexes, state and operation codes, and the
// command and status words that join the controller and the datapath.
// ----------------------------------------------------------------------------
package rmc_pkg;

    localparam int WORD_BITS = 40;
    localparam int CNT_W     = $clog2(WORD_BITS);
    localparam int IDX_W     = 2;
    localparam int CHAR_W    = 7;

    typedef logic [WORD_BITS-1:0] word_t;
    typedef logic [CHAR_W-1:0]    char_t;

    localparam word_t MODULUS_RESET  = word_t'(2);
    localparam word_t EXPONENT_RESET = word_t'(65537);
    localparam char_t PRINT_LOW      = char_t'(32);
    localparam char_t PRINT_HIGH     = char_t'(126);
    localparam char_t STAR_CHAR      = char_t'(42);

    typedef enum logic [IDX_W-1:0] {
        REG_MODULUS      = 2'd0,
        REG_EXPONENT     = 2'd1,
        REG_DECRYPT_MODE = 2'd2
    } reg_index_t;

    typedef enum logic [1:0] {
        OP_REDUCE,
        OP_MUL,
        OP_SQR
    } mul_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_CHECK,
        ST_MUL,
        ST_SQR,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic    load;
        logic    mul_init;
        logic    step;
        mul_op_t op;
        logic    wb;
        logic    exp_shift;
        logic    finish;
    } cmd_t;

    typedef struct packed {
        logic mod_zero;
        logic exp_zero;
        logic exp_lsb;
        logic exp_last;
        logic cnt_last;
    } status_t;

endpackage

// ===== rtl/rmc_datapath.sv =====
// ----------------------------------------------------------------------------
// RSA modular exponentiation datapath
// Holds the operands of one word and a bit-serial modular multiplier that
// takes one multiplier bit per cycle. The initial reduction of the input
// word runs on the same unit as a multiplication by one.
// ----------------------------------------------------------------------------
module rmc_datapath (
    input  logic             clk,
    input  logic             rst_n,
    input  rmc_pkg::cmd_t    cmd,
    output rmc_pkg::status_t status,
    input  rmc_pkg::word_t   modulus,
    input  rmc_pkg::word_t   exponent,
    input  logic             decrypt_mode,
    input  rmc_pkg::word_t   value_in,
    output rmc_pkg::word_t   result
);

    localparam int SUM_W = rmc_pkg::WORD_BITS + 2;

    rmc_pkg::word_t acc_reg;
    rmc_pkg::word_t base_reg;
    rmc_pkg::word_t exp_reg;
    rmc_pkg::word_t sh_reg;
    rmc_pkg::word_t prod_reg;
    logic [rmc_pkg::CNT_W-1:0] cnt_reg;
    logic [rmc_pkg::CNT_W-1:0] cnt_next;

    rmc_pkg::word_t mul_a;
    rmc_pkg::word_t base_in;
    rmc_pkg::word_t prod_next;
    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] n1;
    logic [SUM_W-1:0] n2;

    always_comb
    begin
        case (cmd.op)
            rmc_pkg::OP_REDUCE: mul_a = rmc_pkg::word_t'(1);
            rmc_pkg::OP_MUL:    mul_a = acc_reg;
            rmc_pkg::OP_SQR:    mul_a = base_reg;
            default:            mul_a = base_reg;
        endcase
    end

    // Both operands are below the modulus, so the sum stays below three times it.
    always_comb
    begin
        n1  = {2'b00, modulus};
        n2  = {1'b0, modulus, 1'b0};
        sum = {1'b0, prod_reg, 1'b0} + (sh_reg[rmc_pkg::WORD_BITS-1] ?
                                        {2'b00, mul_a} : {SUM_W{1'b0}});
        if (sum >= n2)
        begin
            prod_next = rmc_pkg::word_t'(sum - n2);
        end
        else if (sum >= n1)
        begin
            prod_next = rmc_pkg::word_t'(sum - n1);
        end
        else
        begin
            prod_next = rmc_pkg::word_t'(sum);
        end
    end

    assign base_in  = decrypt_mode ? value_in :
                      {{(rmc_pkg::WORD_BITS-8){1'b0}}, value_in[7:0]};
    assign cnt_next = cnt_reg + rmc_pkg::CNT_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.load || cmd.mul_init)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.step)
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sh_reg   <= base_in;
            prod_reg <= '0;
            exp_reg  <= exponent;
            acc_reg  <= (modulus > rmc_pkg::word_t'(1)) ? rmc_pkg::word_t'(1) : '0;
        end
        else
        begin
            if (cmd.mul_init)
            begin
                sh_reg   <= base_reg;
                prod_reg <= '0;
            end
            else if (cmd.step)
            begin
                sh_reg   <= {sh_reg[rmc_pkg::WORD_BITS-2:0], 1'b0};
                prod_reg <= prod_next;
            end
            if (cmd.wb)
            begin
                if (cmd.op == rmc_pkg::OP_MUL)
                begin
                    acc_reg <= prod_next;
                end
                else
                begin
                    base_reg <= prod_next;
                end
            end
            if (cmd.exp_shift)
            begin
                exp_reg <= {1'b0, exp_reg[rmc_pkg::WORD_BITS-1:1]};
            end
        end
    end

    always_comb
    begin
        status.mod_zero = (modulus == '0);
        status.exp_zero = (exp_reg == '0);
        status.exp_lsb  = exp_reg[0];
        status.exp_last = (exp_reg[rmc_pkg::WORD_BITS-1:1] == '0);
        status.cnt_last = (cnt_reg == rmc_pkg::CNT_W'(rmc_pkg::WORD_BITS - 1));
    end

    assign result = acc_reg;

endmodule

// ===== rtl/rmc_ctrl.sv =====
// ----------------------------------------------------------------------------
// RSA modular exponentiation controller
// Sequences the input reduction and the right-to-left square-and-multiply
// loop over the exponent bits, one multiplier pass per operation.
// ----------------------------------------------------------------------------
module rmc_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    output rmc_pkg::cmd_t    cmd,
    input  rmc_pkg::status_t status
);

    rmc_pkg::state_t state_reg;
    rmc_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rmc_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.op     = rmc_pkg::OP_REDUCE;
        busy       = 1'b1;
        case (state_reg)
            rmc_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = status.mod_zero ? rmc_pkg::ST_FINISH : rmc_pkg::ST_REDUCE;
                end
            end
            rmc_pkg::ST_REDUCE:
            begin
                cmd.step = 1'b1;
                cmd.op   = rmc_pkg::OP_REDUCE;
                if (status.cnt_last)
                begin
                    cmd.wb     = 1'b1;
                    state_next = rmc_pkg::ST_CHECK;
                end
            end
            rmc_pkg::ST_CHECK:
            begin
                if (status.exp_zero)
                begin
                    state_next = rmc_pkg::ST_FINISH;
                end
                else
                begin
                    cmd.mul_init = 1'b1;
                    state_next   = status.exp_lsb ? rmc_pkg::ST_MUL : rmc_pkg::ST_SQR;
                end
            end
            rmc_pkg::ST_MUL:
            begin
                cmd.step = 1'b1;
                cmd.op   = rmc_pkg::OP_MUL;
                if (status.cnt_last)
                begin
                    cmd.wb = 1'b1;
                    if (status.exp_last)
                    begin
                        state_next = rmc_pkg::ST_FINISH;
                    end
                    else
                    begin
                        cmd.mul_init = 1'b1;
                        state_next   = rmc_pkg::ST_SQR;
                    end
                end
            end
            rmc_pkg::ST_SQR:
            begin
                cmd.step = 1'b1;
                cmd.op   = rmc_pkg::OP_SQR;
                if (status.cnt_last)
                begin
                    cmd.wb        = 1'b1;
                    cmd.exp_shift = 1'b1;
                    state_next    = rmc_pkg::ST_CHECK;
                end
            end
            rmc_pkg::ST_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = rmc_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = rmc_pkg::ST_IDLE;
            end
        endcase
    end

    a_finish_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == rmc_pkg::ST_FINISH |=> state_reg == rmc_pkg::ST_IDLE)
        else $error("finish state not followed by idle");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rmc_pkg::ST_IDLE && start) |=> busy)
        else $error("accepted word did not make the block busy");

    a_mul_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rmc_pkg::ST_MUL && status.cnt_last) |=>
        (state_reg == rmc_pkg::ST_SQR || state_reg == rmc_pkg::ST_FINISH))
        else $error("multiply pass ended in an unexpected state");

endmodule

// ===== rtl/rsa_modexp_cipher_unit.sv =====
// ----------------------------------------------------------------------------
// RSA modular exponentiation cipher unit
// Raises each input word to the configured exponent modulo the configured
// modulus and reports the printable character of the result when decrypting.
//
// Configuration: write modulus, exponent and decrypt_mode through wr_en,
// wr_index and wr_data while busy is low. Reset loads modulus 2, exponent
// 65537 and encrypt mode, and leaves the unit idle.
// Input: a word is taken on a clock edge where start is high and busy is low.
// In encrypt mode only the low byte of value_in is used.
// Output: done is high for one cycle with value_out, char_out and printable.
// The receiver cannot hold a result off; it must take it in that cycle.
// Sequence: a load, the reduction of the input word, then per exponent bit
// a check, a multiply pass when the bit is set and a squaring pass (the top
// bit needs no squaring), and a finish. Every pass runs on the shared
// bit-serial modular multiplier, one multiplier bit per cycle. A new word
// may be started in the cycle that done is high.
// ----------------------------------------------------------------------------
module rsa_modexp_cipher_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_en,
    input  logic [rmc_pkg::IDX_W-1:0]     wr_index,
    input  rmc_pkg::word_t                wr_data,
    input  logic                          start,
    output logic                          busy,
    input  rmc_pkg::word_t                value_in,
    output logic                          done,
    output rmc_pkg::word_t                value_out,
    output rmc_pkg::char_t                char_out,
    output logic                          printable
);

    rmc_pkg::word_t   modulus_reg;
    rmc_pkg::word_t   exponent_reg;
    logic             decrypt_mode_reg;
    logic             done_reg;
    rmc_pkg::word_t   value_out_reg;
    rmc_pkg::char_t   char_out_reg;
    logic             printable_reg;

    rmc_pkg::cmd_t    cmd;
    rmc_pkg::status_t status;
    rmc_pkg::word_t   dp_result;
    logic             pr;

    rmc_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .status (status)
    );

    rmc_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .modulus      (modulus_reg),
        .exponent     (exponent_reg),
        .decrypt_mode (decrypt_mode_reg),
        .value_in     (value_in),
        .result       (dp_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg      <= rmc_pkg::MODULUS_RESET;
            exponent_reg     <= rmc_pkg::EXPONENT_RESET;
            decrypt_mode_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            case (rmc_pkg::reg_index_t'(wr_index))
                rmc_pkg::REG_MODULUS:      modulus_reg      <= wr_data;
                rmc_pkg::REG_EXPONENT:     exponent_reg     <= wr_data;
                rmc_pkg::REG_DECRYPT_MODE: decrypt_mode_reg <= wr_data[0];
                default:                   ;
            endcase
        end
    end

    assign pr = (dp_result >= rmc_pkg::word_t'(rmc_pkg::PRINT_LOW)) &&
                (dp_result <= rmc_pkg::word_t'(rmc_pkg::PRINT_HIGH));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.finish;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            value_out_reg <= dp_result;
            printable_reg <= pr;
            if (!decrypt_mode_reg)
            begin
                char_out_reg <= '0;
            end
            else if (pr)
            begin
                char_out_reg <= dp_result[rmc_pkg::CHAR_W-1:0];
            end
            else
            begin
                char_out_reg <= rmc_pkg::STAR_CHAR;
            end
        end
    end

    assign done      = done_reg;
    assign value_out = value_out_reg;
    assign char_out  = char_out_reg;
    assign printable = printable_reg;

endmodule
